// File: rtl/ddsp_pkg.sv
// Shared widths, constants, register indexes and reset values, controller states and unit control types.
`timescale 1ns / 1ps

package ddsp_pkg;

  // Field widths
  localparam int TS_W    = 13;  // target_speed, signed
  localparam int TT_W    = 12;  // turn_target, signed
  localparam int SPD_W   = 12;  // measured wheel speed magnitude
  localparam int GAIN_W  = 7;   // kp, ki, kd, signed
  localparam int ODIV_W  = 16;  // out_divisor
  localparam int DB_W    = 10;  // drive_deadband
  localparam int MIN_W   = 12;  // min_drive_speed
  localparam int SB_W    = 10;  // stop_band
  localparam int HD_W    = 8;   // hist_divisor
  localparam int PWM_W   = 8;   // motor drive byte

  // Configuration channel
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Internal widths
  localparam int MUL_W   = 14;  // serial multiplier digit count, holds |target_speed| as signed
  localparam int V_W     = 15;  // wheel target, signed
  localparam int E_W     = 16;  // speed error and last error, signed
  localparam int DIFF_W  = 17;  // error change, signed
  localparam int ZONE_W  = 13;  // error dead zone
  localparam int SPLIT_W = 13;  // turn split, signed
  localparam int TTM_W   = 21;  // |turn_target| * TURN_SCALE
  localparam int DIVR_W  = 16;  // divisor width of the serial divider

  // Constants
  localparam int TURN_SCALE = 1000;
  localparam int TURN_DIV   = 289;
  localparam int PWM_MID    = 127;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_DIV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_BAND = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_DIV  = 3'd7;

  // Register reset values
  localparam logic signed [GAIN_W-1:0] KP_RST        = 7'sd10;
  localparam logic signed [GAIN_W-1:0] KI_RST        = 7'sd1;
  localparam logic signed [GAIN_W-1:0] KD_RST        = -7'sd5;
  localparam logic [ODIV_W-1:0]        OUT_DIV_RST   = 16'd1200;
  localparam logic [DB_W-1:0]          DEADBAND_RST  = 10'd50;
  localparam logic [MIN_W-1:0]         MIN_SPEED_RST = 12'd500;
  localparam logic [SB_W-1:0]          STOP_BAND_RST = 10'd10;
  localparam logic [HD_W-1:0]          HIST_DIV_RST  = 8'd30;

  // Controller sequence
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQ_WAIT,
    ST_DZ1,
    ST_DZ1_WAIT,
    ST_DZ2,
    ST_DZ2_WAIT,
    ST_SPL,
    ST_SPL_WAIT,
    ST_PREP,
    ST_ERR,
    ST_KP,
    ST_KP_WAIT,
    ST_KI,
    ST_KI_WAIT,
    ST_KD,
    ST_KD_WAIT,
    ST_PDIV,
    ST_PDIV_WAIT,
    ST_WDONE,
    ST_OUT
  } state_t;

  // Multiply-accumulate unit control
  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctl_t;

endpackage

// File: rtl/ddsp_if.sv
// Valid/ready channel interfaces: command, result and configuration write.
`timescale 1ns / 1ps

interface ddsp_cmd_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ddsp_pkg::TS_W-1:0]      target_speed;
  logic signed [ddsp_pkg::TT_W-1:0]      turn_target;
  logic        [ddsp_pkg::SPD_W-1:0]     left_speed;
  logic        [ddsp_pkg::SPD_W-1:0]     right_speed;

  modport source (output valid, target_speed, turn_target, left_speed, right_speed,
                  input ready);
  modport sink   (input valid, target_speed, turn_target, left_speed, right_speed,
                  output ready);
endinterface

interface ddsp_res_if;
  logic                          valid;
  logic                          ready;
  logic [ddsp_pkg::PWM_W-1:0]    left_pwm;
  logic [ddsp_pkg::PWM_W-1:0]    right_pwm;

  modport source (output valid, left_pwm, right_pwm, input ready);
  modport sink   (input valid, left_pwm, right_pwm, output ready);
endinterface

interface ddsp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ddsp_pkg::CFG_IDX_W-1:0]    index;
  logic [ddsp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/differential_drive_speed_pid.sv
// Top level: two-wheel speed PID controller with serial multiply and divide units.
`timescale 1ns / 1ps

// Each command transfer carries a drive target, a turn target and both measured wheel speed
// magnitudes; the block returns one result with a PWM byte per wheel (127 is stop, 0..254).
// One command is worked at a time. The work of each item is done by the shared restoring
// divider, which resolves one quotient bit per cycle over PW bits, where PW is INTEGRAL_BITS+8
// but never less than 26, for the dead zone (two divides), the turn split and each wheel's
// output scaling, and by the shift-add multiplier, one bit per cycle over 14 bits for the
// dead-zone square and the three gains of each wheel. A new command is taken as soon as the
// result is in the output register, even while that result waits to be taken.
// Configuration writes are accepted every cycle and should only be made while idle; a
// divisor register written as zero acts as one.
module differential_drive_speed_pid #(
  parameter int INTEGRAL_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  ddsp_cmd_if.sink    cmd,
  ddsp_res_if.source  res,
  ddsp_cfg_if.sink    cfg
);

  // PID sum width; never below 26 so the dead-zone square of -4096 fits
  localparam int PW = (INTEGRAL_BITS + 8 > 26) ? INTEGRAL_BITS + 8 : 26;
  localparam int SW = INTEGRAL_BITS + 1;   // integral add width before saturation
  localparam logic signed [INTEGRAL_BITS-1:0] IMAX = {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
  localparam logic signed [INTEGRAL_BITS-1:0] IMIN = {1'b1, {(INTEGRAL_BITS-1){1'b0}}};

  // Configuration registers
  logic signed [ddsp_pkg::GAIN_W-1:0]  kp, ki, kd;
  logic [ddsp_pkg::ODIV_W-1:0]         out_divisor;
  logic [ddsp_pkg::DB_W-1:0]           drive_deadband;
  logic [ddsp_pkg::MIN_W-1:0]          min_drive_speed;
  logic [ddsp_pkg::SB_W-1:0]           stop_band;
  logic [ddsp_pkg::HD_W-1:0]           hist_divisor;

  // Controller
  ddsp_pkg::state_t state, state_next;
  logic             wheel;

  // Captured command
  logic signed [ddsp_pkg::TS_W-1:0]    ts_r;
  logic signed [ddsp_pkg::TT_W-1:0]    tt_r;
  logic [ddsp_pkg::SPD_W-1:0]          la_r, ra_r;

  // Per-item and per-wheel working registers
  logic [ddsp_pkg::ZONE_W-1:0]         zone_r;
  logic signed [ddsp_pkg::SPLIT_W-1:0] split_r;
  logic signed [ddsp_pkg::V_W-1:0]     vt_r;
  logic signed [ddsp_pkg::SPD_W:0]     va_r;
  logic signed [ddsp_pkg::E_W-1:0]     e_r;
  logic signed [INTEGRAL_BITS-1:0]     sum_r;
  logic                                clr_r;
  logic [ddsp_pkg::PWM_W-1:0]          lpwm_r, rpwm_r;

  // Wheel state
  logic signed [INTEGRAL_BITS-1:0]     integ [2];
  logic signed [ddsp_pkg::E_W-1:0]     last_err [2];

  // Result register
  logic                                out_valid;
  logic [ddsp_pkg::PWM_W-1:0]          out_left, out_right;

  // Unit connections
  ddsp_pkg::mac_ctl_t                  mac_ctl;
  logic signed [ddsp_pkg::MUL_W-1:0]   mac_mult;
  logic signed [PW-1:0]                mac_opnd;
  logic                                mac_busy;
  logic signed [PW-1:0]                acc;
  logic                                div_start;
  logic [PW-1:0]                       div_dvd;
  logic [ddsp_pkg::DIVR_W-1:0]         div_dvs;
  logic                                div_busy;
  logic [PW-1:0]                       div_q;

  // Derived operands
  logic [ddsp_pkg::TS_W-1:0]           ts_mag;
  logic [ddsp_pkg::TT_W-1:0]           tt_mag;
  logic [ddsp_pkg::TTM_W-1:0]          tt_scaled;
  logic [ddsp_pkg::DIVR_W-1:0]         hd_eff, od_eff;
  logic [PW-1:0]                       p_mag;
  logic signed [ddsp_pkg::DIFF_W-1:0]  diff;
  logic [ddsp_pkg::SPLIT_W-2:0]        split_mag;

  // Wheel target shaping
  logic signed [ddsp_pkg::V_W-1:0]     v_raw, v_shp, db_s, mn_s, sb_s;
  logic [ddsp_pkg::SPD_W-1:0]          a_mag;
  logic signed [ddsp_pkg::SPD_W:0]     va_raw;

  // Error and integral
  logic signed [ddsp_pkg::E_W-1:0]     e_raw, e_val, zone_s;
  logic                                clr;
  logic signed [INTEGRAL_BITS-1:0]     i_base, s_sat;
  logic signed [SW-1:0]                s_wide;

  // Output shaping
  logic                                q_big;
  logic [6:0]                          c_mag;
  logic signed [8:0]                   c_s, c_fin;
  logic [ddsp_pkg::PWM_W-1:0]          pwm;

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == ddsp_pkg::ST_IDLE);
  assign res.valid     = out_valid;
  assign res.left_pwm  = out_left;
  assign res.right_pwm = out_right;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kp              <= ddsp_pkg::KP_RST;
      ki              <= ddsp_pkg::KI_RST;
      kd              <= ddsp_pkg::KD_RST;
      out_divisor     <= ddsp_pkg::OUT_DIV_RST;
      drive_deadband  <= ddsp_pkg::DEADBAND_RST;
      min_drive_speed <= ddsp_pkg::MIN_SPEED_RST;
      stop_band       <= ddsp_pkg::STOP_BAND_RST;
      hist_divisor    <= ddsp_pkg::HIST_DIV_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ddsp_pkg::REG_KP:        kp              <= cfg.data[ddsp_pkg::GAIN_W-1:0];
        ddsp_pkg::REG_KI:        ki              <= cfg.data[ddsp_pkg::GAIN_W-1:0];
        ddsp_pkg::REG_KD:        kd              <= cfg.data[ddsp_pkg::GAIN_W-1:0];
        ddsp_pkg::REG_OUT_DIV:   out_divisor     <= cfg.data[ddsp_pkg::ODIV_W-1:0];
        ddsp_pkg::REG_DEADBAND:  drive_deadband  <= cfg.data[ddsp_pkg::DB_W-1:0];
        ddsp_pkg::REG_MIN_SPEED: min_drive_speed <= cfg.data[ddsp_pkg::MIN_W-1:0];
        ddsp_pkg::REG_STOP_BAND: stop_band       <= cfg.data[ddsp_pkg::SB_W-1:0];
        ddsp_pkg::REG_HIST_DIV:  hist_divisor    <= cfg.data[ddsp_pkg::HD_W-1:0];
        default: ;
      endcase
    end
  end

  // Operand preparation
  always_comb begin
    ts_mag    = ts_r[ddsp_pkg::TS_W-1] ? ddsp_pkg::TS_W'(-ts_r) : ddsp_pkg::TS_W'(ts_r);
    tt_mag    = tt_r[ddsp_pkg::TT_W-1] ? ddsp_pkg::TT_W'(-tt_r) : ddsp_pkg::TT_W'(tt_r);
    tt_scaled = ddsp_pkg::TTM_W'(tt_mag) * ddsp_pkg::TTM_W'(ddsp_pkg::TURN_SCALE);
    hd_eff    = (hist_divisor == '0) ? ddsp_pkg::DIVR_W'(1) : ddsp_pkg::DIVR_W'(hist_divisor);
    od_eff    = (out_divisor == '0) ? ddsp_pkg::DIVR_W'(1) : ddsp_pkg::DIVR_W'(out_divisor);
    p_mag     = acc[PW-1] ? PW'(-acc) : PW'(acc);
    diff      = ddsp_pkg::DIFF_W'(e_r) - ddsp_pkg::DIFF_W'(last_err[wheel]);
    split_mag = div_q[ddsp_pkg::SPLIT_W-1:1];
  end

  // Wheel target: split, sign of measured speed, deadband and minimum speed
  always_comb begin
    db_s  = $signed(ddsp_pkg::V_W'(drive_deadband));
    mn_s  = $signed(ddsp_pkg::V_W'(min_drive_speed));
    sb_s  = $signed(ddsp_pkg::V_W'(stop_band));
    v_raw = wheel ? (ddsp_pkg::V_W'(ts_r) + ddsp_pkg::V_W'(split_r))
                  : (ddsp_pkg::V_W'(ts_r) - ddsp_pkg::V_W'(split_r));
    a_mag = wheel ? ra_r : la_r;
    va_raw = v_raw[ddsp_pkg::V_W-1] ? -$signed({1'b0, a_mag}) : $signed({1'b0, a_mag});
    if (v_raw > db_s && v_raw < mn_s) begin
      v_shp = mn_s;
    end else if (v_raw < -db_s && v_raw > -mn_s) begin
      v_shp = -mn_s;
    end else if (v_raw >= -db_s && v_raw <= db_s) begin
      v_shp = '0;
    end else begin
      v_shp = v_raw;
    end
  end

  // Error with dead zone, stop reset and saturated integral
  always_comb begin
    zone_s = $signed(ddsp_pkg::E_W'(zone_r));
    e_raw  = ddsp_pkg::E_W'(vt_r) - ddsp_pkg::E_W'(va_r);
    e_val  = (e_raw < zone_s && e_raw > -zone_s) ? '0 : e_raw;
    clr    = (vt_r == '0) && (ddsp_pkg::V_W'(va_r) < sb_s) && (ddsp_pkg::V_W'(va_r) > -sb_s);
    i_base = clr ? '0 : integ[wheel];
    s_wide = SW'(i_base) + SW'(e_val);
    if (s_wide[SW-1] != s_wide[SW-2]) begin
      s_sat = s_wide[SW-1] ? IMIN : IMAX;
    end else begin
      s_sat = s_wide[INTEGRAL_BITS-1:0];
    end
  end

  // Clamp, sign check against the target and offset to a drive byte
  always_comb begin
    q_big = |div_q[PW-1:7];
    c_mag = q_big ? 7'd127 : div_q[6:0];
    c_s   = acc[PW-1] ? -$signed({2'b00, c_mag}) : $signed({2'b00, c_mag});
    c_fin = ((c_s > 0 && vt_r > 0) || (c_s < 0 && vt_r < 0)) ? c_s : '0;
    pwm   = ddsp_pkg::PWM_W'(c_fin + 9'(ddsp_pkg::PWM_MID));
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ddsp_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Next state and unit commands
  always_comb begin
    state_next = state;
    mac_ctl    = '0;
    mac_mult   = '0;
    mac_opnd   = '0;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dvs    = '0;
    unique case (state)
      ddsp_pkg::ST_IDLE: begin
        if (cmd.valid) state_next = ddsp_pkg::ST_SQ;
      end
      ddsp_pkg::ST_SQ: begin
        mac_ctl.start = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_mult      = {1'b0, ts_mag};
        mac_opnd      = PW'({1'b0, ts_mag});
        state_next    = ddsp_pkg::ST_SQ_WAIT;
      end
      ddsp_pkg::ST_SQ_WAIT: begin
        if (!mac_busy) state_next = ddsp_pkg::ST_DZ1;
      end
      ddsp_pkg::ST_DZ1: begin
        div_start  = 1'b1;
        div_dvd    = PW'(acc);
        div_dvs    = ddsp_pkg::DIVR_W'(ts_mag) + ddsp_pkg::DIVR_W'(1);
        state_next = ddsp_pkg::ST_DZ1_WAIT;
      end
      ddsp_pkg::ST_DZ1_WAIT: begin
        if (!div_busy) state_next = ddsp_pkg::ST_DZ2;
      end
      ddsp_pkg::ST_DZ2: begin
        div_start  = 1'b1;
        div_dvd    = div_q;
        div_dvs    = hd_eff;
        state_next = ddsp_pkg::ST_DZ2_WAIT;
      end
      ddsp_pkg::ST_DZ2_WAIT: begin
        if (!div_busy) state_next = ddsp_pkg::ST_SPL;
      end
      ddsp_pkg::ST_SPL: begin
        div_start  = 1'b1;
        div_dvd    = PW'(tt_scaled);
        div_dvs    = ddsp_pkg::DIVR_W'(ddsp_pkg::TURN_DIV);
        state_next = ddsp_pkg::ST_SPL_WAIT;
      end
      ddsp_pkg::ST_SPL_WAIT: begin
        if (!div_busy) state_next = ddsp_pkg::ST_PREP;
      end
      ddsp_pkg::ST_PREP: begin
        state_next = ddsp_pkg::ST_ERR;
      end
      ddsp_pkg::ST_ERR: begin
        state_next = ddsp_pkg::ST_KP;
      end
      ddsp_pkg::ST_KP: begin
        mac_ctl.start = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_mult      = ddsp_pkg::MUL_W'(kp);
        mac_opnd      = PW'(e_r);
        state_next    = ddsp_pkg::ST_KP_WAIT;
      end
      ddsp_pkg::ST_KP_WAIT: begin
        if (!mac_busy) state_next = ddsp_pkg::ST_KI;
      end
      ddsp_pkg::ST_KI: begin
        mac_ctl.start = 1'b1;
        mac_mult      = ddsp_pkg::MUL_W'(ki);
        mac_opnd      = PW'(sum_r);
        state_next    = ddsp_pkg::ST_KI_WAIT;
      end
      ddsp_pkg::ST_KI_WAIT: begin
        if (!mac_busy) state_next = ddsp_pkg::ST_KD;
      end
      ddsp_pkg::ST_KD: begin
        mac_ctl.start = 1'b1;
        mac_mult      = ddsp_pkg::MUL_W'(kd);
        mac_opnd      = PW'(diff);
        state_next    = ddsp_pkg::ST_KD_WAIT;
      end
      ddsp_pkg::ST_KD_WAIT: begin
        if (!mac_busy) state_next = ddsp_pkg::ST_PDIV;
      end
      ddsp_pkg::ST_PDIV: begin
        div_start  = 1'b1;
        div_dvd    = p_mag;
        div_dvs    = od_eff;
        state_next = ddsp_pkg::ST_PDIV_WAIT;
      end
      ddsp_pkg::ST_PDIV_WAIT: begin
        if (!div_busy) state_next = ddsp_pkg::ST_WDONE;
      end
      ddsp_pkg::ST_WDONE: begin
        state_next = wheel ? ddsp_pkg::ST_OUT : ddsp_pkg::ST_PREP;
      end
      ddsp_pkg::ST_OUT: begin
        if (!out_valid || res.ready) state_next = ddsp_pkg::ST_IDLE;
      end
      default: state_next = ddsp_pkg::ST_IDLE;
    endcase
  end

  // Command capture and working registers
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      ts_r <= cmd.target_speed;
      tt_r <= cmd.turn_target;
      la_r <= cmd.left_speed;
      ra_r <= cmd.right_speed;
    end
    if (state == ddsp_pkg::ST_DZ2_WAIT && !div_busy) zone_r <= div_q[ddsp_pkg::ZONE_W-1:0];
    if (state == ddsp_pkg::ST_SPL_WAIT && !div_busy) begin
      split_r <= tt_r[ddsp_pkg::TT_W-1] ? -$signed({1'b0, split_mag})
                                         : $signed({1'b0, split_mag});
    end
    if (state == ddsp_pkg::ST_PREP) begin
      vt_r <= v_shp;
      va_r <= va_raw;
    end
    if (state == ddsp_pkg::ST_ERR) begin
      e_r   <= e_val;
      sum_r <= s_sat;
      clr_r <= clr;
    end
    if (state == ddsp_pkg::ST_WDONE) begin
      if (wheel) rpwm_r <= pwm;
      else       lpwm_r <= pwm;
    end
  end

  // Wheel select and wheel state; integral held while the output clamps, unless the stop reset clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel       <= 1'b0;
      integ[0]    <= '0;
      integ[1]    <= '0;
      last_err[0] <= '0;
      last_err[1] <= '0;
    end else if (cmd.valid && cmd.ready) begin
      wheel <= 1'b0;
    end else if (state == ddsp_pkg::ST_WDONE) begin
      wheel           <= 1'b1;
      last_err[wheel] <= e_r;
      if (!q_big)     integ[wheel] <= sum_r;
      else if (clr_r) integ[wheel] <= '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ddsp_pkg::ST_OUT && (!out_valid || res.ready)) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ddsp_pkg::ST_OUT && (!out_valid || res.ready)) begin
      out_left  <= lpwm_r;
      out_right <= rpwm_r;
    end
  end

  // Serial units
  ddsp_mac #(
    .AW (PW),
    .MW (ddsp_pkg::MUL_W)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .mult (mac_mult),
    .opnd (mac_opnd),
    .busy (mac_busy),
    .acc  (acc)
  );

  ddsp_div #(
    .DW (PW),
    .VW (ddsp_pkg::DIVR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Checks
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mac_busy && div_busy))
    else $error("multiplier and divider busy together");

  a_pwm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_left != {ddsp_pkg::PWM_W{1'b1}} && out_right != {ddsp_pkg::PWM_W{1'b1}}))
    else $error("drive byte out of range");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ddsp_pkg::ST_OUT)
    else $error("result loaded outside the output step");

endmodule

// File: rtl/ddsp_mac.sv
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle, shift and add.
`timescale 1ns / 1ps

module ddsp_mac #(
  parameter int AW = 40,
  parameter int MW = 14
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ddsp_pkg::mac_ctl_t       ctl,
  input  logic signed [MW-1:0]     mult,
  input  logic signed [AW-1:0]     opnd,
  output logic                     busy,
  output logic signed [AW-1:0]     acc
);

  localparam int CW = (MW > 1) ? $clog2(MW) : 1;

  logic [MW-1:0]          mreg;
  logic signed [AW-1:0]   areg;
  logic [CW-1:0]          cnt;
  logic                   last;

  assign last = (cnt == CW'(MW - 1));

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (last) busy <= 1'b0;
    end
  end

  // Shift-add datapath; the sign bit of the multiplier weighs negative
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mreg <= mult;
      areg <= opnd;
      if (ctl.clear) acc <= '0;
    end else if (busy) begin
      mreg <= mreg >> 1;
      areg <= areg <<< 1;
      if (mreg[0]) begin
        acc <= last ? (acc - areg) : (acc + areg);
      end
    end
  end

endmodule

// File: rtl/ddsp_div.sv
// Restoring unsigned divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module ddsp_div #(
  parameter int DW = 40,
  parameter int VW = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DW-1:0]   dividend,
  input  logic [VW-1:0]   divisor,
  output logic            busy,
  output logic [DW-1:0]   quotient
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic [VW-1:0]  rem;
  logic [VW-1:0]  dvs;
  logic [DW-1:0]  q;
  logic [CW-1:0]  cnt;
  logic [VW:0]    trial;
  logic           fits;

  // Trial subtract of the partial remainder
  assign trial = {rem, q[DW-1]};
  assign fits  = (trial >= {1'b0, dvs});

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == CW'(DW - 1)) busy <= 1'b0;
    end
  end

  // Quotient shifts in from the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      q   <= {q[DW-2:0], fits};
      rem <= fits ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
    end
  end

  assign quotient = q;

endmodule
